// ===== sv/rvic_pkg.sv =====
// rvic_pkg: shared types, phase codes, opcode constants and font table
// for the retro VM instruction core. No dependencies.
`timescale 1ns / 1ps
package rvic_pkg;

	// input transaction
	typedef struct packed {
		logic        cmd;
		logic [11:0] load_addr;
		logic [7:0]  load_byte;
		logic        key_down;
		logic [3:0]  key_code;
		logic [7:0]  random_byte;
	} in_t;

	// result transaction
	typedef struct packed {
		logic [11:0] pc_after;
		logic [15:0] instr_word;
		logic        undefined_op;
		logic        clear_display;
		logic        waiting_key;
		logic        sound_on;
	} out_t;

	// controller phases (also the controller state)
	localparam logic [3:0] PH_CLEAR = 4'd0;
	localparam logic [3:0] PH_IDLE  = 4'd1;
	localparam logic [3:0] PH_LOAD  = 4'd2;
	localparam logic [3:0] PH_F0    = 4'd3;
	localparam logic [3:0] PH_F1    = 4'd4;
	localparam logic [3:0] PH_RX    = 4'd5;
	localparam logic [3:0] PH_RY    = 4'd6;
	localparam logic [3:0] PH_EXEC  = 4'd7;
	localparam logic [3:0] PH_FLAG  = 4'd8;
	localparam logic [3:0] PH_BRD   = 4'd9;
	localparam logic [3:0] PH_BWR   = 4'd10;
	localparam logic [3:0] PH_DONE  = 4'd11;

	typedef struct packed {
		logic [3:0] phase;
		logic       take;
		logic       push;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic blk_last;
		logic op_flag;
		logic op_blk;
		logic is_step;
		logic out_busy;
	} status_t;

	// top nibble opcodes
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEI  = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDI  = 4'h6;
	localparam logic [3:0] OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDIX = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	// ALU sub-ops
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// low-byte codes
	localparam logic [7:0] LB_CLS  = 8'hE0;
	localparam logic [7:0] LB_RET  = 8'hEE;
	localparam logic [7:0] LB_SKP  = 8'h9E;
	localparam logic [7:0] LB_SKNP = 8'hA1;
	localparam logic [7:0] LB_GDT  = 8'h07;
	localparam logic [7:0] LB_WKEY = 8'h0A;
	localparam logic [7:0] LB_SDT  = 8'h15;
	localparam logic [7:0] LB_SST  = 8'h18;
	localparam logic [7:0] LB_ADDX = 8'h1E;
	localparam logic [7:0] LB_FONT = 8'h29;
	localparam logic [7:0] LB_BCD  = 8'h33;
	localparam logic [7:0] LB_STOR = 8'h55;
	localparam logic [7:0] LB_LOAD = 8'h65;

	localparam logic [11:0] PC_RESET  = 12'h200;
	localparam int          FONT_LEN  = 80;

	localparam logic [7:0] FONT_ROM [0:FONT_LEN-1] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

endpackage

// ===== sv/rvic_ram.sv =====
// rvic_ram: generic single-port RAM, registered read (held during writes).
// No dependencies.
`timescale 1ns / 1ps
module rvic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== sv/rvic_ctrl.sv =====
// rvic_ctrl: sequencing state machine for the instruction core.
// Depends on rvic_pkg.
`timescale 1ns / 1ps
module rvic_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  rvic_pkg::status_t sts,
	output rvic_pkg::cmd_t    cmd
);

	logic [3:0] state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rvic_pkg::PH_CLEAR: if (sts.clr_last) state_d = rvic_pkg::PH_IDLE;
			rvic_pkg::PH_IDLE: begin
				if (item_valid) begin
					state_d = sts.is_step ? rvic_pkg::PH_F0 : rvic_pkg::PH_LOAD;
				end
			end
			rvic_pkg::PH_LOAD: state_d = rvic_pkg::PH_DONE;
			rvic_pkg::PH_F0:   state_d = rvic_pkg::PH_F1;
			rvic_pkg::PH_F1:   state_d = rvic_pkg::PH_RX;
			rvic_pkg::PH_RX:   state_d = rvic_pkg::PH_RY;
			rvic_pkg::PH_RY:   state_d = rvic_pkg::PH_EXEC;
			rvic_pkg::PH_EXEC: begin
				if (sts.op_flag) state_d = rvic_pkg::PH_FLAG;
				else if (sts.op_blk) state_d = rvic_pkg::PH_BRD;
				else state_d = rvic_pkg::PH_DONE;
			end
			rvic_pkg::PH_FLAG: state_d = rvic_pkg::PH_DONE;
			rvic_pkg::PH_BRD:  state_d = rvic_pkg::PH_BWR;
			rvic_pkg::PH_BWR: begin
				state_d = sts.blk_last ? rvic_pkg::PH_DONE : rvic_pkg::PH_BRD;
			end
			rvic_pkg::PH_DONE: if (!sts.out_busy) state_d = rvic_pkg::PH_IDLE;
			default: state_d = rvic_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvic_pkg::PH_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != rvic_pkg::PH_IDLE);
	assign cmd.phase  = state_q;
	assign cmd.take   = (state_q == rvic_pkg::PH_IDLE) && item_valid;
	assign cmd.push   = (state_q == rvic_pkg::PH_DONE) && !sts.out_busy;

endmodule

// ===== sv/rvic_dpath.sv =====
// rvic_dpath: architectural registers, memories, decode/execute and result
// register. Depends on rvic_pkg and rvic_ram.
`timescale 1ns / 1ps
module rvic_dpath #(
	parameter int MEM_BYTES   = 4096,
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rvic_pkg::in_t     item,
	input  rvic_pkg::cmd_t    cmd,
	output rvic_pkg::status_t sts,
	output logic              result_valid,
	input  logic              result_stall,
	output rvic_pkg::out_t    result
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int SW = $clog2(STACK_DEPTH);

	// address reduction modulo memory size (at most eight subtractions)
	function automatic logic [AW-1:0] maddr(input logic [11:0] a);
		logic [16:0] v;
		v = {5'd0, a};
		for (int k = 0; k < 8; k++) begin
			if (v >= 17'(MEM_BYTES)) v = v - 17'(MEM_BYTES);
		end
		return v[AW-1:0];
	endfunction

	rvic_pkg::in_t in_q;
	logic [AW-1:0] clr_cnt_q;
	logic [7:0]    hi_q, lo_q, vx_q, flag_q, delay_q, sound_q;
	logic [11:0]   pc_q, idx_q;
	logic [SW-1:0] sp_q;
	logic [3:0]    cnt_q;
	logic          undef_q, clr_q, waitk_q;
	logic [15:0]   rv_q;
	logic [STACK_DEPTH-1:0] sv_q;
	logic          rvalid_q, svalid_q;
	logic          out_v_q;
	rvic_pkg::out_t out_q;

	logic [3:0] op, x, y, n;
	logic [7:0] kk;
	logic [11:0] nnn;
	assign op  = hi_q[7:4];
	assign x   = hi_q[3:0];
	assign y   = lo_q[7:4];
	assign n   = lo_q[3:0];
	assign kk  = lo_q;
	assign nnn = {x, lo_q};

	logic is_store, is_load;
	assign is_store = (op == rvic_pkg::OP_MISC) && (kk == rvic_pkg::LB_STOR);
	assign is_load  = (op == rvic_pkg::OP_MISC) && (kk == rvic_pkg::LB_LOAD);

	// memories
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wd, mem_rd;
	logic          reg_we;
	logic [3:0]    reg_addr;
	logic [7:0]    reg_wd, reg_rd, reg_rde;
	logic          stk_we;
	logic [SW-1:0] stk_addr;
	logic [11:0]   stk_rd, stk_rde;

	rvic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wd), .rdata(mem_rd));
	rvic_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
		.clk(clk), .we(reg_we), .addr(reg_addr), .wdata(reg_wd), .rdata(reg_rd));
	rvic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .addr(stk_addr), .wdata(pc_q + 12'd2), .rdata(stk_rd));

	assign reg_rde = rvalid_q ? reg_rd : 8'd0;
	assign stk_rde = svalid_q ? stk_rd : 12'd0;

	logic [SW-1:0] sp_inc, sp_dec;
	assign sp_inc = (sp_q == SW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SW'(STACK_DEPTH - 1) : sp_q - 1'b1;

	logic [11:0] blk_a;
	assign blk_a = idx_q + {8'd0, cnt_q};

	// execute decode
	logic [11:0] ex_next, ex_idx, nxt2;
	logic [7:0]  ex_rd, ex_flag, ex_dly, ex_snd, vy;
	logic [8:0]  sum9;
	logic        ex_rwe, ex_undef, ex_clr, ex_wait, ex_push, ex_pop, hit;
	always_comb begin
		vy       = reg_rde;
		nxt2     = pc_q + 12'd4;
		ex_next  = pc_q + 12'd2;
		ex_idx   = idx_q;
		ex_rd    = 8'd0;
		ex_flag  = 8'd0;
		ex_dly   = delay_q;
		ex_snd   = sound_q;
		ex_rwe   = 1'b0;
		ex_undef = 1'b0;
		ex_clr   = 1'b0;
		ex_wait  = 1'b0;
		ex_push  = 1'b0;
		ex_pop   = 1'b0;
		sum9     = {1'b0, vx_q} + {1'b0, vy};
		hit      = in_q.key_down && ({4'd0, in_q.key_code} == vx_q);
		unique case (op)
			rvic_pkg::OP_SYS: begin
				if ({x, kk} == {4'd0, rvic_pkg::LB_CLS}) ex_clr = 1'b1;
				else if ({x, kk} == {4'd0, rvic_pkg::LB_RET}) begin
					ex_pop  = 1'b1;
					ex_next = stk_rde;
				end else ex_undef = 1'b1;
			end
			rvic_pkg::OP_JP: ex_next = nnn;
			rvic_pkg::OP_CALL: begin
				ex_push = 1'b1;
				ex_next = nnn;
			end
			rvic_pkg::OP_SEI:  if (vx_q == kk) ex_next = nxt2;
			rvic_pkg::OP_SNEI: if (vx_q != kk) ex_next = nxt2;
			rvic_pkg::OP_SER: begin
				if (n != 4'd0) ex_undef = 1'b1;
				else if (vx_q == vy) ex_next = nxt2;
			end
			rvic_pkg::OP_LDI: begin
				ex_rwe = 1'b1;
				ex_rd  = kk;
			end
			rvic_pkg::OP_ADDI: begin
				ex_rwe = 1'b1;
				ex_rd  = vx_q + kk;
			end
			rvic_pkg::OP_ALU: begin
				ex_rwe = 1'b1;
				case (n)
					rvic_pkg::ALU_MOV: ex_rd = vy;
					rvic_pkg::ALU_OR:  ex_rd = vx_q | vy;
					rvic_pkg::ALU_AND: ex_rd = vx_q & vy;
					rvic_pkg::ALU_XOR: ex_rd = vx_q ^ vy;
					rvic_pkg::ALU_ADD: begin
						ex_rd   = sum9[7:0];
						ex_flag = {7'd0, sum9[8]};
					end
					rvic_pkg::ALU_SUB: begin
						ex_rd   = vx_q - vy;
						ex_flag = {7'd0, vx_q >= vy};
					end
					rvic_pkg::ALU_SHR: begin
						ex_rd   = {1'b0, vx_q[7:1]};
						ex_flag = {7'd0, vx_q[0]};
					end
					rvic_pkg::ALU_SBN: begin
						ex_rd   = vy - vx_q;
						ex_flag = {7'd0, vy >= vx_q};
					end
					rvic_pkg::ALU_SHL: begin
						ex_rd   = {vx_q[6:0], 1'b0};
						ex_flag = {7'd0, vx_q[7]};
					end
					default: begin
						ex_rwe   = 1'b0;
						ex_undef = 1'b1;
					end
				endcase
			end
			rvic_pkg::OP_SNER: begin
				if (n != 4'd0) ex_undef = 1'b1;
				else if (vx_q != vy) ex_next = nxt2;
			end
			rvic_pkg::OP_LDIX: ex_idx = nnn;
			rvic_pkg::OP_JPV0: ex_next = {4'd0, vy} + nnn;
			rvic_pkg::OP_RND: begin
				ex_rwe = 1'b1;
				ex_rd  = in_q.random_byte & kk;
			end
			rvic_pkg::OP_DRW: ;
			rvic_pkg::OP_KEY: begin
				if (kk == rvic_pkg::LB_SKP) begin
					if (hit) ex_next = nxt2;
				end else if (kk == rvic_pkg::LB_SKNP) begin
					if (!hit) ex_next = nxt2;
				end else ex_undef = 1'b1;
			end
			rvic_pkg::OP_MISC: begin
				case (kk)
					rvic_pkg::LB_GDT: begin
						ex_rwe = 1'b1;
						ex_rd  = delay_q;
					end
					rvic_pkg::LB_WKEY: begin
						if (in_q.key_down) begin
							ex_rwe = 1'b1;
							ex_rd  = {4'd0, in_q.key_code};
						end else begin
							ex_wait = 1'b1;
							ex_next = pc_q;
						end
					end
					rvic_pkg::LB_SDT:  ex_dly = vx_q;
					rvic_pkg::LB_SST:  ex_snd = vx_q;
					rvic_pkg::LB_ADDX: ex_idx = idx_q + {4'd0, vx_q};
					rvic_pkg::LB_FONT: ex_idx = {6'd0, vx_q[3:0], 2'd0} + {8'd0, vx_q[3:0]};
					rvic_pkg::LB_BCD, rvic_pkg::LB_STOR, rvic_pkg::LB_LOAD: ;
					default: ex_undef = 1'b1;
				endcase
			end
			default: ;
		endcase
	end

	// memory port steering
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = '0;
		mem_wd   = item.load_byte;
		reg_we   = 1'b0;
		reg_addr = x;
		reg_wd   = ex_rd;
		stk_we   = 1'b0;
		stk_addr = sp_dec;
		case (cmd.phase)
			rvic_pkg::PH_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_cnt_q;
				mem_wd   = (clr_cnt_q < AW'(rvic_pkg::FONT_LEN)) ?
					rvic_pkg::FONT_ROM[clr_cnt_q[6:0]] : 8'd0;
			end
			rvic_pkg::PH_LOAD: begin
				mem_we   = 1'b1;
				mem_addr = maddr(in_q.load_addr);
				mem_wd   = in_q.load_byte;
			end
			rvic_pkg::PH_F0: mem_addr = maddr(pc_q);
			rvic_pkg::PH_F1: mem_addr = maddr(pc_q + 12'd1);
			rvic_pkg::PH_RY: reg_addr = (op == rvic_pkg::OP_JPV0) ? 4'd0 : y;
			rvic_pkg::PH_EXEC: begin
				reg_we   = ex_rwe;
				stk_we   = ex_push;
				stk_addr = sp_q;
			end
			rvic_pkg::PH_FLAG: begin
				reg_we   = 1'b1;
				reg_addr = 4'hF;
				reg_wd   = flag_q;
			end
			rvic_pkg::PH_BRD: begin
				reg_addr = cnt_q;
				mem_addr = maddr(blk_a);
			end
			rvic_pkg::PH_BWR: begin
				reg_addr = cnt_q;
				reg_wd   = mem_rd;
				reg_we   = is_load;
				mem_we   = is_store;
				mem_addr = maddr(blk_a);
				mem_wd   = reg_rde;
			end
			default: ;
		endcase
	end

	// control state and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			pc_q      <= rvic_pkg::PC_RESET;
			idx_q     <= '0;
			sp_q      <= '0;
			delay_q   <= '0;
			sound_q   <= '0;
			rv_q      <= '0;
			sv_q      <= '0;
			rvalid_q  <= 1'b0;
			svalid_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.phase == rvic_pkg::PH_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (reg_we) rv_q[reg_addr] <= 1'b1;
			else rvalid_q <= rv_q[reg_addr];
			if (stk_we) sv_q[stk_addr] <= 1'b1;
			else svalid_q <= sv_q[stk_addr];
			if (cmd.phase == rvic_pkg::PH_EXEC) begin
				pc_q    <= ex_next;
				idx_q   <= ex_idx;
				delay_q <= ex_dly;
				sound_q <= ex_snd;
				if (ex_push) sp_q <= sp_inc;
				else if (ex_pop) sp_q <= sp_dec;
			end
			if (cmd.push) out_v_q <= 1'b1;
			else if (!result_stall) out_v_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_q    <= item;
			hi_q    <= 8'd0;
			lo_q    <= 8'd0;
			undef_q <= 1'b0;
			clr_q   <= 1'b0;
			waitk_q <= 1'b0;
		end
		if (cmd.phase == rvic_pkg::PH_F1) hi_q <= mem_rd;
		if (cmd.phase == rvic_pkg::PH_RX) lo_q <= mem_rd;
		if (cmd.phase == rvic_pkg::PH_RY) vx_q <= reg_rde;
		if (cmd.phase == rvic_pkg::PH_EXEC) begin
			flag_q  <= ex_flag;
			undef_q <= ex_undef;
			clr_q   <= ex_clr;
			waitk_q <= ex_wait;
			cnt_q   <= 4'd0;
		end
		if (cmd.phase == rvic_pkg::PH_BWR) cnt_q <= cnt_q + 4'd1;
		if (cmd.push) begin
			out_q.pc_after      <= pc_q;
			out_q.instr_word    <= {hi_q, lo_q};
			out_q.undefined_op  <= undef_q;
			out_q.clear_display <= clr_q;
			out_q.waiting_key   <= waitk_q;
			out_q.sound_on      <= (sound_q != 8'd0);
		end
	end

	assign sts.clr_last = (clr_cnt_q == AW'(MEM_BYTES - 1));
	assign sts.blk_last = (cnt_q == x);
	assign sts.op_flag  = (op == rvic_pkg::OP_ALU) && ((n == rvic_pkg::ALU_ADD) ||
		(n == rvic_pkg::ALU_SUB) || (n == rvic_pkg::ALU_SHR) ||
		(n == rvic_pkg::ALU_SBN) || (n == rvic_pkg::ALU_SHL));
	assign sts.op_blk   = is_store || is_load;
	assign sts.is_step  = item.cmd;
	assign sts.out_busy = out_v_q && result_stall;

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

// ===== sv/retro_vm_instruction_core.sv =====
// retro_vm_instruction_core: top level, controller plus datapath.
// Depends on rvic_pkg, rvic_ctrl, rvic_dpath.
//
// One transaction at a time. After reset the core writes the font and zeros
// into all of main memory, holding item_stall high. A memory-load item
// passes through a load step and a done step; an instruction through two
// fetch reads and two register-file reads through single-port memories,
// execute and result, plus a flag write for flag-setting ALU ops, and a
// read step and a write step per byte for block register store/load (x+1
// bytes), since each byte crosses the register file and main memory. A
// result waits in an output register while the next item is taken.
`timescale 1ns / 1ps
module retro_vm_instruction_core #(
	parameter int MEM_BYTES   = 4096,
	parameter int STACK_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  rvic_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_stall,
	output rvic_pkg::out_t result
);

	rvic_pkg::cmd_t    cmd;
	rvic_pkg::status_t sts;

	rvic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid),
		.item_stall(item_stall), .sts(sts), .cmd(cmd));

	rvic_dpath #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dpath (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd), .sts(sts),
		.result_valid(result_valid), .result_stall(result_stall), .result(result));

endmodule

// ===== sv/rvic_checker.sv =====
// rvic_checker: port-level assertions for the instruction core, bound to
// the top level. Depends on rvic_pkg.
`timescale 1ns / 1ps
module rvic_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_stall,
	input rvic_pkg::out_t result,
	input logic           result_valid,
	input logic           result_stall
);

	// memory clearing pass blocks items straight after reset
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> item_stall) else $error("item taken during clear");

	// one transaction at a time
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall) else $error("back-to-back take");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result dropped");

	// a new result only follows work in progress
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall)) else $error("spurious result");

	// a single instruction cannot both clear the screen and be undefined
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.clear_display && result.undefined_op))
		else $error("conflicting flags");

endmodule

bind retro_vm_instruction_core rvic_checker u_checker (
	.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_stall(item_stall),
	.result(result), .result_valid(result_valid), .result_stall(result_stall));

// ===== test/tb_retro_vm_instruction_core.sv =====
// tb_retro_vm_instruction_core: self-checking bench for the retro VM instruction core.
// Depends on rvic_pkg and retro_vm_instruction_core; builds programs, predicts each result.
`timescale 1ns / 1ps
module tb_retro_vm_instruction_core;

	localparam int MEM_SIZE   = 4096;
	localparam int RET_DEPTH  = 16;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	rvic_pkg::in_t  item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	rvic_pkg::out_t result;

	retro_vm_instruction_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #1 clk = ~clk;

	// shadow machine state
	logic [7:0]  vm_mem [0:MEM_SIZE-1];
	logic [7:0]  vm_v [0:15];
	logic [11:0] vm_stack [0:RET_DEPTH-1];
	logic [3:0]  vm_sp;
	logic [11:0] vm_pc;
	logic [11:0] vm_i;
	logic [7:0]  vm_delay;
	logic [7:0]  vm_sound;

	rvic_pkg::in_t  pending_items [$];
	rvic_pkg::out_t expected_results [$];
	bit   failed = 1'b0;
	bit   quiet_gaps = 1'b0;
	bit   hold_for_drain = 1'b0;
	int   idle_cycles = 0;

	task automatic reset_machine();
		for (int a = 0; a < MEM_SIZE; a++)
			vm_mem[a] = (a < rvic_pkg::FONT_LEN) ? rvic_pkg::FONT_ROM[a] : 8'h00;
		for (int r = 0; r < 16; r++) vm_v[r] = 8'h00;
		for (int s = 0; s < RET_DEPTH; s++) vm_stack[s] = 12'h000;
		vm_sp = '0;
		vm_pc = rvic_pkg::PC_RESET;
		vm_i = '0;
		vm_delay = '0;
		vm_sound = '0;
	endtask

	// execute one transaction on the shadow machine
	function automatic rvic_pkg::out_t execute_item(rvic_pkg::in_t it);
		rvic_pkg::out_t o;
		logic [7:0]  hi, lo, vx, vy, kk;
		logic [3:0]  x, y, n;
		logic [11:0] nnn, nxt;
		logic [8:0]  sum;
		logic        hit;
		o = '0;
		if (!it.cmd) begin
			vm_mem[it.load_addr] = it.load_byte;
		end else begin
			hi = vm_mem[vm_pc];
			lo = vm_mem[vm_pc + 12'd1];
			o.instr_word = {hi, lo};
			x = hi[3:0]; y = lo[7:4]; n = lo[3:0]; kk = lo;
			nnn = {hi[3:0], lo};
			vx = vm_v[x]; vy = vm_v[y];
			nxt = vm_pc + 12'd2;
			case (hi[7:4])
				rvic_pkg::OP_SYS: begin
					if (hi == 8'h00 && lo == rvic_pkg::LB_CLS) o.clear_display = 1'b1;
					else if (hi == 8'h00 && lo == rvic_pkg::LB_RET) begin
						vm_sp = vm_sp - 4'd1;
						nxt = vm_stack[vm_sp];
					end else o.undefined_op = 1'b1;
				end
				rvic_pkg::OP_JP: nxt = nnn;
				rvic_pkg::OP_CALL: begin
					vm_stack[vm_sp] = nxt;
					vm_sp = vm_sp + 4'd1;
					nxt = nnn;
				end
				rvic_pkg::OP_SEI:  if (vx == kk) nxt = nxt + 12'd2;
				rvic_pkg::OP_SNEI: if (vx != kk) nxt = nxt + 12'd2;
				rvic_pkg::OP_SER: begin
					if (n != 0) o.undefined_op = 1'b1;
					else if (vx == vy) nxt = nxt + 12'd2;
				end
				rvic_pkg::OP_LDI:  vm_v[x] = kk;
				rvic_pkg::OP_ADDI: vm_v[x] = vx + kk;
				rvic_pkg::OP_ALU: begin
					case (n)
						rvic_pkg::ALU_MOV: vm_v[x] = vy;
						rvic_pkg::ALU_OR:  vm_v[x] = vx | vy;
						rvic_pkg::ALU_AND: vm_v[x] = vx & vy;
						rvic_pkg::ALU_XOR: vm_v[x] = vx ^ vy;
						rvic_pkg::ALU_ADD: begin
							sum = {1'b0, vx} + {1'b0, vy};
							vm_v[x] = sum[7:0]; vm_v[15] = {7'd0, sum[8]};
						end
						rvic_pkg::ALU_SUB: begin
							vm_v[x] = vx - vy; vm_v[15] = {7'd0, vx >= vy};
						end
						rvic_pkg::ALU_SHR: begin
							vm_v[x] = vx >> 1; vm_v[15] = {7'd0, vx[0]};
						end
						rvic_pkg::ALU_SBN: begin
							vm_v[x] = vy - vx; vm_v[15] = {7'd0, vy >= vx};
						end
						rvic_pkg::ALU_SHL: begin
							vm_v[x] = vx << 1; vm_v[15] = {7'd0, vx[7]};
						end
						default: o.undefined_op = 1'b1;
					endcase
				end
				rvic_pkg::OP_SNER: begin
					if (n != 0) o.undefined_op = 1'b1;
					else if (vx != vy) nxt = nxt + 12'd2;
				end
				rvic_pkg::OP_LDIX: vm_i = nnn;
				rvic_pkg::OP_JPV0: nxt = {4'd0, vm_v[0]} + nnn;
				rvic_pkg::OP_RND:  vm_v[x] = it.random_byte & kk;
				rvic_pkg::OP_DRW: ;
				rvic_pkg::OP_KEY: begin
					hit = it.key_down && ({4'd0, it.key_code} == vx);
					if (kk == rvic_pkg::LB_SKP) begin
						if (hit) nxt = nxt + 12'd2;
					end else if (kk == rvic_pkg::LB_SKNP) begin
						if (!hit) nxt = nxt + 12'd2;
					end else o.undefined_op = 1'b1;
				end
				default: begin
					case (kk)
						rvic_pkg::LB_GDT: vm_v[x] = vm_delay;
						rvic_pkg::LB_WKEY: begin
							if (it.key_down) vm_v[x] = {4'd0, it.key_code};
							else begin
								o.waiting_key = 1'b1;
								nxt = vm_pc;
							end
						end
						rvic_pkg::LB_SDT:  vm_delay = vx;
						rvic_pkg::LB_SST:  vm_sound = vx;
						rvic_pkg::LB_ADDX: vm_i = vm_i + {4'd0, vx};
						rvic_pkg::LB_FONT: vm_i = vx[3:0] * 12'd5;
						rvic_pkg::LB_BCD: ;
						rvic_pkg::LB_STOR: for (int k = 0; k <= x; k++)
							vm_mem[vm_i + k[11:0]] = vm_v[k];
						rvic_pkg::LB_LOAD: for (int k = 0; k <= x; k++)
							vm_v[k] = vm_mem[vm_i + k[11:0]];
						default: o.undefined_op = 1'b1;
					endcase
				end
			endcase
			vm_pc = nxt;
		end
		o.pc_after = vm_pc;
		o.sound_on = (vm_sound != 0);
		return o;
	endfunction

	function automatic rvic_pkg::in_t load_item(logic [11:0] a, logic [7:0] b);
		rvic_pkg::in_t it;
		it = rvic_pkg::in_t'({$urandom, $urandom});
		it.cmd = 1'b0; it.load_addr = a; it.load_byte = b;
		return it;
	endfunction

	function automatic rvic_pkg::in_t step_item();
		rvic_pkg::in_t it;
		it = rvic_pkg::in_t'({$urandom, $urandom});
		it.cmd = 1'b1;
		return it;
	endfunction

	// place a word at the shadow PC of the program being built
	logic [11:0] build_pc;
	task automatic put_word(logic [15:0] w);
		pending_items.push_back(load_item(build_pc, w[15:8]));
		pending_items.push_back(load_item(build_pc + 12'd1, w[7:0]));
	endtask

	// instruction with random operands, biased towards defined words
	function automatic logic [15:0] random_word();
		logic [15:0] w;
		logic [7:0] lbs [13];
		lbs = '{rvic_pkg::LB_GDT, rvic_pkg::LB_WKEY, rvic_pkg::LB_SDT, rvic_pkg::LB_SST,
			rvic_pkg::LB_ADDX, rvic_pkg::LB_FONT, rvic_pkg::LB_BCD, rvic_pkg::LB_STOR,
			rvic_pkg::LB_LOAD, rvic_pkg::LB_GDT, rvic_pkg::LB_SDT, rvic_pkg::LB_SST,
			rvic_pkg::LB_FONT};
		w = 16'($urandom);
		if ($urandom_range(0, 9) != 0) begin
			case (w[15:12])
				rvic_pkg::OP_SYS: w[11:0] = ($urandom_range(0, 1)) ?
					{4'h0, rvic_pkg::LB_CLS} : {4'h0, rvic_pkg::LB_RET};
				rvic_pkg::OP_SER, rvic_pkg::OP_SNER: w[3:0] = 4'h0;
				rvic_pkg::OP_ALU: w[3:0] = ($urandom_range(0, 8) == 8) ?
					rvic_pkg::ALU_SHL : 4'($urandom_range(0, 7));
				rvic_pkg::OP_KEY: w[7:0] = $urandom_range(0, 1) ?
					rvic_pkg::LB_SKP : rvic_pkg::LB_SKNP;
				rvic_pkg::OP_MISC: w[7:0] = lbs[$urandom_range(0, 12)];
				default: ;
			endcase
		end
		return w;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!(item_valid && item_stall)) begin
			if (hold_for_drain && expected_results.size() != 0) begin
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0 &&
					(quiet_gaps || $urandom_range(0, 99) >= 12)) begin
				item_valid <= 1'b1;
				item <= pending_items.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// predict on acceptance
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			expected_results.push_back(execute_item(item));
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_stall <= 1'b0;
		else result_stall <= !quiet_gaps && ($urandom_range(0, 99) < 12);
	end

	// monitor
	always @(posedge clk) begin
		rvic_pkg::out_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $realtime, result);
				failed = 1'b1;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.pc_after !== exp_r.pc_after) begin
					$display("%0t: pc_after expected %h actual %h", $realtime,
						exp_r.pc_after, result.pc_after);
					failed = 1'b1;
				end
				if (result.instr_word !== exp_r.instr_word) begin
					$display("%0t: instr_word expected %h actual %h", $realtime,
						exp_r.instr_word, result.instr_word);
					failed = 1'b1;
				end
				if (result.undefined_op !== exp_r.undefined_op) begin
					$display("%0t: undefined_op expected %b actual %b", $realtime,
						exp_r.undefined_op, result.undefined_op);
					failed = 1'b1;
				end
				if (result.clear_display !== exp_r.clear_display) begin
					$display("%0t: clear_display expected %b actual %b", $realtime,
						exp_r.clear_display, result.clear_display);
					failed = 1'b1;
				end
				if (result.waiting_key !== exp_r.waiting_key) begin
					$display("%0t: waiting_key expected %b actual %b", $realtime,
						exp_r.waiting_key, result.waiting_key);
					failed = 1'b1;
				end
				if (result.sound_on !== exp_r.sound_on) begin
					$display("%0t: sound_on expected %b actual %b", $realtime,
						exp_r.sound_on, result.sound_on);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog: cycles with no accepted transaction (long clearing pass included)
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus: programs are laid out where the PC will be when each step runs
	initial begin
		logic [15:0] dir_words [20];
		logic [15:0] w;
		int n_items;
		dir_words = '{16'h00E0, 16'h60FF, 16'h61FF, 16'h8014, 16'h8235, 16'h8306,
			16'h840E, 16'h8017, 16'h3000, 16'h4001, 16'h5010, 16'h9010, 16'h5011,
			16'h8008, 16'hAFFF, 16'hF01E, 16'hF029, 16'hFF55, 16'hE09E, 16'hFFFF};
		reset_machine();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, flags, undefined words, store of all registers
		for (int d = 0; d < 20; d++) begin
			wait (pending_items.size() == 0 && expected_results.size() == 0);
			build_pc = vm_pc;
			put_word(dir_words[d]);
			pending_items.push_back(step_item());
		end
		n_items = 0;
		// subsequent programs: place random words at the predicted PC just before stepping
		wait (pending_items.size() == 0 && expected_results.size() == 0);
		// stack wrap, call/return and key wait handled via a PC tracker from the shadow model
		while (n_items < 1550) begin
			if (n_items == 699) begin
				hold_for_drain = 1'b1;
				wait (expected_results.size() == 0 && pending_items.size() == 0);
				hold_for_drain = 1'b0;
			end
			quiet_gaps = (n_items >= 300 && n_items < 450);
			wait (pending_items.size() == 0 && expected_results.size() == 0);
			build_pc = vm_pc;
			if ($urandom_range(0, 19) == 0)
				pending_items.push_back(load_item(12'($urandom), 8'($urandom)));
			else begin
				w = random_word();
				if (w[15:12] == rvic_pkg::OP_MISC && w[7:0] == rvic_pkg::LB_STOR &&
						vm_i > 12'hF00)
					w[7:0] = rvic_pkg::LB_LOAD;
				put_word(w);
				pending_items.push_back(step_item());
			end
			n_items += 3;
		end
		wait (pending_items.size() == 0 && expected_results.size() == 0);
		repeat (60) @(posedge clk);
		if (!failed) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
